@@ design/mcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_pkg: shared types and constants
// Widths, command and status codes, and the register indexes of the
// muon cut partition block.
// ----------------------------------------------------------------------------
package mcp_pkg;
	localparam int MaxTracks = 1024;
	localparam int AW = $clog2(MaxTracks);
	localparam int CW = AW + 1;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] REG_CUT_MODE = 2'd0;
	localparam logic [1:0] REG_KEEP     = 2'd1;
	localparam logic [1:0] REG_COSINE   = 2'd2;
	localparam logic [1:0] REG_MOMENTUM = 2'd3;

	localparam logic [1:0] MODE_ANGLE  = 2'd0;
	localparam logic [1:0] MODE_MOM_IN = 2'd1;

	typedef struct packed {
		logic signed [15:0] ax, ay, az, bx, by, bz;
		logic signed [15:0] cosine;
	} angle_req_t;
endpackage

@@ design/mcp_angle.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_angle: scattering angle test
// Decides cos(angle) >= cut with squared integer products over five
// registered stages; multiplies sit in stages one, three and four.
// ----------------------------------------------------------------------------
module mcp_angle (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  mcp_pkg::angle_req_t   req,
	output logic                  done,
	output logic                  below
);
	// Stage 1: component products.
	logic signed [31:0] pa_s1 [3];
	logic signed [31:0] pb_s1 [3];
	logic signed [31:0] pd_s1 [3];
	logic signed [15:0] c_s1;
	// Stage 2: sums; the squared norms stay below 2^32.
	logic [31:0] na_s2, nb_s2;
	logic signed [33:0] dot_s2;
	logic signed [15:0] c_s2;
	// Stage 3: squares and norm product.
	logic [63:0] nn_s3;
	logic [63:0] d2_s3;
	logic [31:0] c2_s3;
	logic zero_s3, dneg_s3, cpos_s3, cnp_s3;
	// Stage 4: cut square times each half of the norm product.
	logic [63:0] pl_s4, ph_s4;
	logic [93:0] lhs_s4;
	logic zero_s4, dneg_s4, cpos_s4, cnp_s4;
	// Stage 5: partials summed into the right-hand side.
	logic [95:0] rhs_s5;
	logic [93:0] lhs_s5;
	logic zero_s5, dneg_s5, cpos_s5, cnp_s5;
	logic [4:0] v_q;

	logic [31:0] ud;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else v_q <= {v_q[3:0], start};
	end

	always_comb begin
		ud = dot_s2[33] ? 32'(-dot_s2) : 32'(dot_s2);
	end

	always_ff @(posedge clk) begin
		pa_s1[0] <= req.ax * req.ax; pa_s1[1] <= req.ay * req.ay;
		pa_s1[2] <= req.az * req.az;
		pb_s1[0] <= req.bx * req.bx; pb_s1[1] <= req.by * req.by;
		pb_s1[2] <= req.bz * req.bz;
		pd_s1[0] <= req.ax * req.bx; pd_s1[1] <= req.ay * req.by;
		pd_s1[2] <= req.az * req.bz;
		c_s1 <= req.cosine;

		na_s2 <= 32'(pa_s1[0]) + 32'(pa_s1[1]) + 32'(pa_s1[2]);
		nb_s2 <= 32'(pb_s1[0]) + 32'(pb_s1[1]) + 32'(pb_s1[2]);
		dot_s2 <= 34'(pd_s1[0]) + 34'(pd_s1[1]) + 34'(pd_s1[2]);
		c_s2 <= c_s1;

		nn_s3 <= 64'(na_s2) * 64'(nb_s2);
		d2_s3 <= 64'(ud) * 64'(ud);
		c2_s3 <= 32'(c_s2 * c_s2);
		zero_s3 <= (na_s2 == '0) || (nb_s2 == '0);
		dneg_s3 <= dot_s2[33];
		cpos_s3 <= c_s2 > 0;
		cnp_s3 <= c_s2 <= 0;

		pl_s4 <= 64'(c2_s3) * 64'(nn_s3[31:0]);
		ph_s4 <= 64'(c2_s3) * 64'(nn_s3[63:32]);
		lhs_s4 <= {d2_s3, 30'd0};
		zero_s4 <= zero_s3; dneg_s4 <= dneg_s3;
		cpos_s4 <= cpos_s3; cnp_s4 <= cnp_s3;

		rhs_s5 <= {ph_s4, 32'd0} + 96'(pl_s4);
		lhs_s5 <= lhs_s4;
		zero_s5 <= zero_s4; dneg_s5 <= dneg_s4;
		cpos_s5 <= cpos_s4; cnp_s5 <= cnp_s4;
	end

	// Sign cases first, then the magnitude compare.
	always_comb begin
		done = v_q[4];
		priority if (zero_s5) below = 1'b1;
		else if (!dneg_s5 && cnp_s5) below = 1'b1;
		else if (dneg_s5 && cpos_s5) below = 1'b0;
		else if (!dneg_s5) below = 96'(lhs_s5) >= rhs_s5;
		else below = 96'(lhs_s5) <= rhs_s5;
	end
endmodule

@@ design/muon_cut_partition.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muon_cut_partition: muon track store with cut partitioning
// Loads tracks, flags each against the cut, partitions on command and
// returns kept track indices.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on s_axis (cmd, directions, momenta, slot)
// and exactly one result beat leaves on m_axis (status, totals, index).
// The user writes the registers via cfg_we/cfg_addr/cfg_data only while idle;
// the block does not enforce it. A load presents its result after the five
// stages of the angle multiplier and the flag and order memory write; a read
// after the synchronous memory read; a rejected load or read and an unused
// command directly. A run walks the store with two pointers over the flag
// and order memories, which have one read and one write port; a step that
// advances the low pointer passes the read and wait states, one that drops
// the high pointer also the decide state and one that swaps also the second
// write state. After the result beat is taken the block returns to idle,
// where it accepts the next command. Reset clears the counts, cut mode and
// momentum cut and sets keep to 1 and the cosine cut to 32767; memories are
// not cleared, as only loaded entries are ever read. The block works on one
// command at a time and the result sits in an output register; when the
// receiver stalls the block holds it and takes no new command until taken.
// ----------------------------------------------------------------------------
module muon_cut_partition (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd[1:0], in_dx, in_dy, in_dz, out_dx, out_dy, out_dz, momentum_in,
	// momentum_out, slot_index[9:0] from bit 0 up; zero fill to 144 bits
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], loaded_total[10:0], passed_total[10:0], muon_index[9:0]
	output logic [39:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [15:0]  cfg_data
);
	localparam int AW = mcp_pkg::AW;
	localparam int CW = mcp_pkg::CW;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LWAIT = 4'd1;
	localparam logic [3:0] S_RWAIT = 4'd2;
	localparam logic [3:0] S_PRD   = 4'd4;
	localparam logic [3:0] S_PWAIT = 4'd5;
	localparam logic [3:0] S_PDEC  = 4'd6;
	localparam logic [3:0] S_PSW2  = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q;
	logic [1:0] cut_mode_q;
	logic keep_q;
	logic signed [15:0] cos_q;
	logic [15:0] mth_q;
	logic [CW-1:0] count_q, split_q, lo_q, hi_q;
	logic [1:0] status_q;
	logic [AW-1:0] idx_q;
	logic mom_below_q;
	logic [AW-1:0] o_lo_q;
	logic f_lo_q;

	// Flag and order memories, one entry per track.
	logic mem_f [mcp_pkg::MaxTracks];
	logic [AW-1:0] mem_o [mcp_pkg::MaxTracks];
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic wf;
	logic [AW-1:0] wo;
	logic rf;
	logic [AW-1:0] ro;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_f[waddr] <= wf;
			mem_o[waddr] <= wo;
		end
		rf <= mem_f[raddr];
		ro <= mem_o[raddr];
	end

	// Input fields.
	logic [1:0] cmd;
	logic [15:0] mom_in, mom_out;
	logic [9:0] slot;
	mcp_pkg::angle_req_t areq;
	assign cmd     = s_axis_tdata[1:0];
	assign mom_in  = s_axis_tdata[113:98];
	assign mom_out = s_axis_tdata[129:114];
	assign slot    = s_axis_tdata[139:130];
	assign areq.ax = s_axis_tdata[17:2];
	assign areq.ay = s_axis_tdata[33:18];
	assign areq.az = s_axis_tdata[49:34];
	assign areq.bx = s_axis_tdata[65:50];
	assign areq.by = s_axis_tdata[81:66];
	assign areq.bz = s_axis_tdata[97:82];
	assign areq.cosine = cos_q;

	logic acc;
	assign s_axis_tready = (state_q == S_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;

	logic [CW-1:0] kept;
	logic [CW-1:0] rpos;
	logic [AW-1:0] hm1;
	logic full;
	assign kept = keep_q ? CW'(count_q - split_q) : split_q;
	assign rpos = keep_q ? CW'(split_q + CW'(slot)) : CW'(slot);
	assign hm1  = AW'(hi_q - 1'b1);
	assign full = count_q >= CW'(mcp_pkg::MaxTracks);

	// The angle test only starts for a load that will be stored.
	logic adone, abelow;
	mcp_angle u_angle (
		.clk(clk), .arst_n(arst_n),
		.start(acc && cmd == mcp_pkg::CMD_LOAD && !full),
		.req(areq), .done(adone), .below(abelow)
	);

	// Memory port selection.
	always_comb begin
		we = 1'b0; waddr = count_q[AW-1:0]; wf = 1'b0; wo = count_q[AW-1:0];
		raddr = lo_q[AW-1:0];
		unique case (state_q)
			S_IDLE: raddr = rpos[AW-1:0];
			S_LWAIT: begin
				we = adone;
				wf = (cut_mode_q == mcp_pkg::MODE_ANGLE) ? abelow : mom_below_q;
			end
			S_PRD: raddr = lo_q[AW-1:0];
			S_PWAIT: raddr = hm1;
			S_PDEC: begin
				// Swap: old high entry goes to lo.
				we = f_lo_q ? 1'b0 : rf;
				waddr = lo_q[AW-1:0]; wf = rf; wo = ro;
				raddr = hm1;
			end
			S_PSW2: begin
				we = 1'b1; waddr = hm1; wf = f_lo_q; wo = o_lo_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; cut_mode_q <= '0; keep_q <= 1'b1;
			cos_q <= 16'sd32767; mth_q <= '0;
			count_q <= '0; split_q <= '0; lo_q <= '0; hi_q <= '0;
			status_q <= mcp_pkg::ST_OK; idx_q <= '0;
			mom_below_q <= 1'b0; f_lo_q <= 1'b0; o_lo_q <= '0;
		end else begin
			// Register writes.
			if (cfg_we) begin
				unique case (cfg_addr)
					mcp_pkg::REG_CUT_MODE: cut_mode_q <= cfg_data[1:0];
					mcp_pkg::REG_KEEP:     keep_q <= cfg_data[0];
					mcp_pkg::REG_COSINE:   cos_q <= cfg_data;
					mcp_pkg::REG_MOMENTUM: mth_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (acc) begin
					status_q <= mcp_pkg::ST_OK; idx_q <= '0;
					mom_below_q <= (cut_mode_q == mcp_pkg::MODE_MOM_IN)
						? (mom_in <= mth_q) : (mom_out <= mth_q);
					priority if (cmd == mcp_pkg::CMD_LOAD) begin
						if (full) begin
							status_q <= mcp_pkg::ST_FULL; state_q <= S_OUT;
						end else state_q <= S_LWAIT;
					end else if (cmd == mcp_pkg::CMD_RUN) begin
						lo_q <= '0; hi_q <= count_q; state_q <= S_PRD;
					end else if (cmd == mcp_pkg::CMD_READ) begin
						if (CW'(slot) >= kept) begin
							status_q <= mcp_pkg::ST_RANGE; state_q <= S_OUT;
						end else state_q <= S_RWAIT;
					end else state_q <= S_OUT;
				end
				S_LWAIT: if (adone) begin
					idx_q <= count_q[AW-1:0];
					count_q <= CW'(count_q + 1'b1);
					state_q <= S_OUT;
				end
				// ro holds the entry addressed when the read was accepted.
				S_RWAIT: begin idx_q <= ro; state_q <= S_OUT; end
				S_PRD: begin
					if (lo_q >= hi_q) begin
						split_q <= lo_q; state_q <= S_OUT;
					end else state_q <= S_PWAIT;
				end
				S_PWAIT: begin
					// rf/ro hold entry lo.
					f_lo_q <= rf; o_lo_q <= ro;
					if (rf) begin lo_q <= CW'(lo_q + 1'b1); state_q <= S_PRD; end
					else state_q <= S_PDEC;
				end
				S_PDEC: begin
					// rf/ro hold entry hi-1.
					if (f_lo_q) state_q <= S_PRD;
					else if (rf) state_q <= S_PSW2;
					else begin hi_q <= CW'(hi_q - 1'b1); state_q <= S_PRD; end
				end
				S_PSW2: begin hi_q <= CW'(hi_q - 1'b1); state_q <= S_PRD; end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = {6'd0, idx_q, kept, count_q, status_q};

`ifndef SYNTHESIS
	a_split_le: assert property (@(posedge clk) disable iff (!arst_n)
		split_q <= count_q) else $error("split beyond count");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PWAIT) |-> (lo_q < hi_q)) else $error("pointers crossed");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && status_q == mcp_pkg::ST_FULL) |->
		(count_q == CW'(mcp_pkg::MaxTracks))) else $error("false full");
`endif
endmodule
